// ----- rtl/gtr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gtr_pkg;

   // fixed glyph geometry and special codes
   localparam int GLYPH_WIDTH = 8;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // field widths
   localparam int CODE_W   = 8;
   localparam int ROWIN_W  = 5;
   localparam int CURSOR_W = 16;
   localparam int COLOR_W  = 32;
   localparam int INDEX_W  = 32;
   localparam int MASK_W   = 8;
   localparam int FW_W     = 14;
   localparam int PPS_W    = 14;
   localparam int GH_W     = 6;

   // largest number of rows drawn for one character
   localparam int ROW_LIMIT = 32;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_PIXELS_PER_SL = 2'd1;
   localparam logic [1:0] REG_GLYPH_HEIGHT  = 2'd2;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 14'd1024;
   localparam logic [PPS_W-1:0] PPS_RESET          = 14'd1024;
   localparam logic [GH_W-1:0]  GLYPH_HEIGHT_RESET = 6'd16;

   // item operation
   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_CURSOR = 2'd1,
      MODE_PRINT  = 2'd2
   } mode_type;

endpackage

`default_nettype wire

// ----- rtl/gtr_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

// request channel: one operation item
interface gtr_req_if;
   logic                                valid;
   logic                                ready;
   gtr_pkg::mode_type                   mode;
   logic [gtr_pkg::CODE_W-1:0]          char_code;
   logic [gtr_pkg::ROWIN_W-1:0]         glyph_row;
   logic [gtr_pkg::MASK_W-1:0]          glyph_bits;
   logic [gtr_pkg::CURSOR_W-1:0]        cursor_col;
   logic [gtr_pkg::CURSOR_W-1:0]        cursor_line;
   logic [gtr_pkg::COLOR_W-1:0]         color;

   modport source (
      output valid, mode, char_code, glyph_row, glyph_bits, cursor_col, cursor_line, color,
      input  ready
   );
   modport sink (
      input  valid, mode, char_code, glyph_row, glyph_bits, cursor_col, cursor_line, color,
      output ready
   );
endinterface

// response channel: one glyph row item
interface gtr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gtr_pkg::INDEX_W-1:0]         pixel_index;
   logic [gtr_pkg::MASK_W-1:0]          pixel_mask;
   logic [gtr_pkg::COLOR_W-1:0]         pixel_color;
   logic                                last_row;

   modport source (
      output valid, pixel_index, pixel_mask, pixel_color, last_row,
      input  ready
   );
   modport sink (
      input  valid, pixel_index, pixel_mask, pixel_color, last_row,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/glyph_text_renderer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Character generator for an 8-pixel-wide bitmap font.
// req_ch takes operation items: mode 0 writes one glyph row into the glyph
// memory, mode 1 places the cursor, mode 2 draws a character at the cursor
// (newline only moves the cursor to the start of the next text line).
// rsp_ch gives one item per glyph row drawn: framebuffer pixel index of the
// row start, 8-bit mask (bit 7 leftmost), color and a last-row flag.
// The APB port holds frame width, pixel stride and glyph height; write it
// only while no character is being drawn.
// On acceptance of a print item the row-address multiply is registered, then
// the start index and glyph memory read, then the output register with the
// first row. After that one row per cycle while rsp_ch does not stall, set by
// the single read port of the glyph memory. A character draws glyph_height
// rows (default 16), capped at MAX_GLYPH_HEIGHT and at 32; req_ch takes no new
// item until the last row is in the output register. Load, cursor and newline
// items keep the unit idle and req_ch ready.
// When rsp_ch stalls, the row sequencer holds and re-reads the same memory
// entry; nothing is lost. Reset clears cursor, control and registers to their
// defaults; the glyph memory keeps its contents and is unknown until written.
module glyph_text_renderer_unit #(
   parameter int GLYPH_COUNT      = 256,
   parameter int MAX_GLYPH_HEIGHT = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   gtr_req_if.sink                              req_ch,
   gtr_rsp_if.source                            rsp_ch,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [gtr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [gtr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [gtr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   localparam int DEPTH   = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int GLYPH_W = $clog2(GLYPH_COUNT);
   localparam int ROW_W   = $clog2(MAX_GLYPH_HEIGHT);
   localparam int HMAX    = (MAX_GLYPH_HEIGHT < gtr_pkg::ROW_LIMIT) ?
                            MAX_GLYPH_HEIGHT : gtr_pkg::ROW_LIMIT;
   localparam int EXT_W   = 10;
   localparam int PROD_W  = gtr_pkg::CURSOR_W + gtr_pkg::PPS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   // configuration registers
   logic [gtr_pkg::FW_W-1:0]  frame_width_ff;
   logic [gtr_pkg::PPS_W-1:0] pps_ff;
   logic [gtr_pkg::GH_W-1:0]  glyph_height_ff;
   logic                      csr_write;

   // control state
   state_type                     state_ff, state_in;
   logic [gtr_pkg::CURSOR_W-1:0]  cursor_x_ff, cursor_x_in;
   logic [gtr_pkg::CURSOR_W-1:0]  cursor_y_ff, cursor_y_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // per-character payload
   logic [ADDR_W-1:0]             base_ff;
   logic [ROW_W-1:0]              last_ff;
   logic [gtr_pkg::COLOR_W-1:0]   color_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [gtr_pkg::CURSOR_W-1:0]  x0_ff;
   logic [gtr_pkg::INDEX_W-1:0]   idx_ff, idx_in;

   // result registers
   logic [gtr_pkg::INDEX_W-1:0]   out_index_ff;
   logic [gtr_pkg::MASK_W-1:0]    out_mask_ff;
   logic [gtr_pkg::COLOR_W-1:0]   out_color_ff;
   logic                          out_last_ff;

   // glyph memory
   logic [gtr_pkg::MASK_W-1:0]    glyph_mem [DEPTH];
   logic [gtr_pkg::MASK_W-1:0]    mem_q_ff;
   logic [ADDR_W-1:0]             rd_addr;
   logic [ADDR_W-1:0]             wr_addr;
   logic                          mem_we;

   // decode of the incoming item
   logic                          req_fire;
   logic [EXT_W-1:0]              code_ext;
   logic [EXT_W-1:0]              glyph_full;
   logic [GLYPH_W-1:0]            glyph_idx;
   logic [ADDR_W-1:0]             glyph_base;
   logic                          row_in_range;
   logic [gtr_pkg::GH_W-1:0]      h_eff;
   logic [gtr_pkg::CURSOR_W-1:0]  x_step;
   logic [gtr_pkg::CURSOR_W-1:0]  y_adv;
   logic                          x_wrap;

   // row sequencer
   logic                          out_load;
   logic                          is_last;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         gtr_pkg::REG_FRAME_WIDTH:   prdata = {18'd0, frame_width_ff};
         gtr_pkg::REG_PIXELS_PER_SL: prdata = {18'd0, pps_ff};
         gtr_pkg::REG_GLYPH_HEIGHT:  prdata = {26'd0, glyph_height_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gtr_pkg::FRAME_WIDTH_RESET;
         pps_ff          <= gtr_pkg::PPS_RESET;
         glyph_height_ff <= gtr_pkg::GLYPH_HEIGHT_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            gtr_pkg::REG_FRAME_WIDTH:   frame_width_ff  <= pwdata[gtr_pkg::FW_W-1:0];
            gtr_pkg::REG_PIXELS_PER_SL: pps_ff          <= pwdata[gtr_pkg::PPS_W-1:0];
            gtr_pkg::REG_GLYPH_HEIGHT:  glyph_height_ff <= pwdata[gtr_pkg::GH_W-1:0];
            default: ;
         endcase
      end
   end

   // item decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // glyph code modulo glyph count, exact while code is below twice the count
   assign code_ext   = {2'b00, req_ch.char_code};
   assign glyph_full = (code_ext >= EXT_W'(GLYPH_COUNT)) ?
                       code_ext - EXT_W'(GLYPH_COUNT) : code_ext;
   assign glyph_idx  = glyph_full[GLYPH_W-1:0];
   assign glyph_base = ADDR_W'(glyph_idx) * ADDR_W'(MAX_GLYPH_HEIGHT);

   assign row_in_range = {2'b00, req_ch.glyph_row} < 7'(MAX_GLYPH_HEIGHT);
   assign wr_addr      = glyph_base + ADDR_W'(req_ch.glyph_row);
   assign mem_we       = req_fire && (req_ch.mode == gtr_pkg::MODE_LOAD) && row_in_range;

   // rows drawn and line advance
   assign h_eff = ({1'b0, glyph_height_ff} > 7'(HMAX)) ? gtr_pkg::GH_W'(HMAX) :
                  glyph_height_ff;

   assign x_step = cursor_x_ff + gtr_pkg::CURSOR_W'(gtr_pkg::GLYPH_WIDTH);
   assign x_wrap = x_step >= {2'b00, frame_width_ff};
   assign y_adv  = cursor_y_ff + {10'd0, h_eff};

   // row sequencer handshake
   assign out_load = !rsp_valid_ff || rsp_ch.ready;
   assign is_last  = (row_ff == last_ff);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.mode)
                  gtr_pkg::MODE_CURSOR: begin
                     cursor_x_in = req_ch.cursor_col;
                     cursor_y_in = req_ch.cursor_line;
                  end
                  gtr_pkg::MODE_PRINT: begin
                     if (req_ch.char_code == gtr_pkg::NEWLINE_CODE) begin
                        cursor_x_in = '0;
                        cursor_y_in = y_adv;
                     end else begin
                        cursor_x_in = x_wrap ? '0 : x_step;
                        cursor_y_in = x_wrap ? y_adv : cursor_y_ff;
                        if (h_eff != '0) begin
                           state_in = ST_SETUP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            // start index and first memory read
            idx_in   = gtr_pkg::INDEX_W'(prod_ff) + gtr_pkg::INDEX_W'(x0_ff);
            row_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + gtr_pkg::INDEX_W'(pps_ff);
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read the row being fetched; a stalled row is read again
   assign rd_addr = base_ff + ADDR_W'(row_in);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-character payload, captured from the pre-advance cursor
   always_ff @(posedge clock) begin
      if (req_fire) begin
         base_ff  <= glyph_base;
         last_ff  <= ROW_W'(h_eff - gtr_pkg::GH_W'(1));
         color_ff <= req_ch.color;
         prod_ff  <= PROD_W'(cursor_y_ff) * PROD_W'(pps_ff);
         x0_ff    <= cursor_x_ff;
      end
      idx_ff <= idx_in;
   end

   // glyph memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[wr_addr] <= req_ch.glyph_bits;
      end
      mem_q_ff <= glyph_mem[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_RUN) && out_load) begin
         out_index_ff <= idx_ff;
         out_mask_ff  <= mem_q_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_index = out_index_ff;
   assign rsp_ch.pixel_mask  = out_mask_ff;
   assign rsp_ch.pixel_color = out_color_ff;
   assign rsp_ch.last_row    = out_last_ff;

endmodule

`default_nettype wire

// ----- dv/gtr_row_checker.sv -----
`timescale 1ns / 1ps

// watches both channels and the register port, predicts glyph rows, compares
module gtr_row_checker
   import gtr_pkg::*;
#(
   parameter int GLYPH_COUNT      = 256,
   parameter int MAX_GLYPH_HEIGHT = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gtr_req_if                         req_mon,
   gtr_rsp_if                         rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         fail_count,
   output int                         rows_pending
);

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [MASK_W-1:0]  mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } glyph_row_type;

   glyph_row_type expected_rows[$];

   // register copies and cursor
   logic [FW_W-1:0]     frame_width;
   logic [PPS_W-1:0]    scan_stride;
   logic [GH_W-1:0]     glyph_height;
   logic [CURSOR_W-1:0] cur_x;
   logic [CURSOR_W-1:0] cur_y;
   logic [MASK_W-1:0]   font_rows [GLYPH_COUNT*MAX_GLYPH_HEIGHT];
   int                  errors = 0;

   // rows actually drawn per character, also the line advance
   function automatic int rows_per_char();
      int h;
      h = int'(glyph_height);
      if (h > MAX_GLYPH_HEIGHT) h = MAX_GLYPH_HEIGHT;
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      return h;
   endfunction

   task automatic report_fail(input string msg);
      $display("%0t ns: glyph row check: %s", $time, msg);
      errors++;
   endtask

   task automatic new_line();
      cur_x = '0;
      cur_y = cur_y + CURSOR_W'(rows_per_char());
   endtask

   // expected rows of one character, then cursor advance
   task automatic draw_char(input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] color);
      int            glyph;
      int            h;
      glyph_row_type row;
      logic [31:0]   row_y;
      glyph = int'(code) % GLYPH_COUNT;
      h = rows_per_char();
      for (int dy = 0; dy < h; dy++) begin
         row_y     = 32'(cur_y) + 32'(dy);
         row.index = 32'(cur_x) + row_y * 32'(scan_stride);
         row.mask  = font_rows[glyph*MAX_GLYPH_HEIGHT + dy];
         row.color = color;
         row.last  = (dy + 1 == h);
         expected_rows.push_back(row);
      end
      cur_x = cur_x + CURSOR_W'(GLYPH_WIDTH);
      if (32'(cur_x) >= 32'(frame_width)) new_line();
   endtask

   // apply one accepted request item
   task automatic apply_request();
      int glyph;
      glyph = int'(req_mon.char_code) % GLYPH_COUNT;
      case (req_mon.mode)
         MODE_LOAD: begin
            if (int'(req_mon.glyph_row) < MAX_GLYPH_HEIGHT)
               font_rows[glyph*MAX_GLYPH_HEIGHT + int'(req_mon.glyph_row)] = req_mon.glyph_bits;
         end
         MODE_CURSOR: begin
            cur_x = req_mon.cursor_col;
            cur_y = req_mon.cursor_line;
         end
         MODE_PRINT: begin
            if (req_mon.char_code == NEWLINE_CODE) new_line();
            else draw_char(req_mon.char_code, req_mon.color);
         end
         default: ;
      endcase
   endtask

   // compare one accepted row item with the oldest expectation
   task automatic check_row();
      glyph_row_type want;
      if (expected_rows.size() == 0) begin
         report_fail($sformatf("unexpected row item index %h", rsp_mon.pixel_index));
      end else begin
         want = expected_rows.pop_front();
         if (rsp_mon.pixel_index !== want.index)
            report_fail($sformatf("pixel_index %h, want %h", rsp_mon.pixel_index, want.index));
         if (rsp_mon.pixel_mask !== want.mask)
            report_fail($sformatf("pixel_mask %h, want %h at index %h",
                                  rsp_mon.pixel_mask, want.mask, want.index));
         if (rsp_mon.pixel_color !== want.color)
            report_fail($sformatf("pixel_color %h, want %h", rsp_mon.pixel_color, want.color));
         if (rsp_mon.last_row !== want.last)
            report_fail($sformatf("last_row %b, want %b at index %h",
                                  rsp_mon.last_row, want.last, want.index));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_width  = FRAME_WIDTH_RESET;
         scan_stride  = PPS_RESET;
         glyph_height = GLYPH_HEIGHT_RESET;
         cur_x        = '0;
         cur_y        = '0;
         expected_rows.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_row();
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_FRAME_WIDTH:   frame_width  = pwdata[FW_W-1:0];
               REG_PIXELS_PER_SL: scan_stride  = pwdata[PPS_W-1:0];
               REG_GLYPH_HEIGHT:  glyph_height = pwdata[GH_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) apply_request();
      end
      rows_pending <= expected_rows.size();
      fail_count   <= errors;
   end

endmodule

// ----- dv/tb_glyph_text_renderer_unit.sv -----
`timescale 1ns / 1ps

module tb_glyph_text_renderer_unit;
   import gtr_pkg::*;

   localparam int       GLYPH_TOTAL     = 256;
   localparam int       STEPS_PER_PHASE = 18;
   localparam int       SETTLE_CYCLES   = 8;
   localparam mode_type MODE_UNUSED     = mode_type'(2'd3);

   typedef struct {
      mode_type            mode;
      logic [CODE_W-1:0]   code;
      logic [ROWIN_W-1:0]  row;
      logic [MASK_W-1:0]   bits;
      logic [CURSOR_W-1:0] col;
      logic [CURSOR_W-1:0] line;
      logic [COLOR_W-1:0]  color;
   } req_item_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gtr_req_if req_ch ();
   gtr_rsp_if rsp_ch ();

   int          send_idle_pct;
   int          recv_idle_pct;
   int          fail_count;
   int          rows_pending;
   int          cur_height;
   logic [31:0] rows_loaded [GLYPH_TOTAL];

   glyph_text_renderer_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   gtr_row_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .pready       (pready),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .fail_count   (fail_count),
      .rows_pending (rows_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // row receiver with random stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // cursor values biased toward the 16-bit edges
   function automatic logic [CURSOR_W-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF - 16'($urandom_range(0, 15));
         1: return 16'($urandom_range(0, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_item_type random_req();
      req_item_type r;
      r.mode  = MODE_UNUSED;
      r.code  = CODE_W'($urandom);
      r.row   = ROWIN_W'($urandom);
      r.bits  = MASK_W'($urandom);
      r.col   = pick_coord();
      r.line  = pick_coord();
      r.color = $urandom;
      return r;
   endfunction

   // present one item, with a random gap first
   task automatic send_req(input req_item_type it);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= it.mode;
      req_ch.char_code   <= it.code;
      req_ch.glyph_row   <= it.row;
      req_ch.glyph_bits  <= it.bits;
      req_ch.cursor_col  <= it.col;
      req_ch.cursor_line <= it.line;
      req_ch.color       <= it.color;
      do @(posedge clock); while (!req_ch.ready);
      if (it.mode == MODE_LOAD) rows_loaded[it.code][it.row] = 1'b1;
   endtask

   task automatic place_cursor(input logic [CURSOR_W-1:0] col, input logic [CURSOR_W-1:0] line);
      req_item_type it;
      it      = random_req();
      it.mode = MODE_CURSOR;
      it.col  = col;
      it.line = line;
      send_req(it);
   endtask

   task automatic print_code(input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] color);
      req_item_type it;
      it       = random_req();
      it.mode  = MODE_PRINT;
      it.code  = code;
      it.color = color;
      send_req(it);
   endtask

   // hold off until every expected row has come, then let the pipe settle
   task automatic drain_rows();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup then access cycle
   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_GLYPH_HEIGHT)
         cur_height = (int'(value[GH_W-1:0]) > ROW_LIMIT) ? ROW_LIMIT : int'(value[GH_W-1:0]);
   endtask

   // one register setting followed by random traffic
   task automatic run_phase(input logic [31:0] fw, input logic [31:0] pps, input logic [31:0] gh,
                            input int s_pct, input int r_pct);
      req_item_type      it;
      int                steps;
      int                sel;
      logic [CODE_W-1:0] code;
      drain_rows();
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      set_reg(REG_FRAME_WIDTH, fw);
      set_reg(REG_PIXELS_PER_SL, pps);
      set_reg(REG_GLYPH_HEIGHT, gh);
      steps = 0;
      while (steps < STEPS_PER_PHASE) begin
         sel = $urandom_range(0, 99);
         steps++;
         it = random_req();
         if (sel < 6) begin
            // unused mode, must be ignored
            send_req(it);
         end else if (sel < 14) begin
            // stray glyph row load
            it.mode = MODE_LOAD;
            send_req(it);
         end else if (sel < 24) begin
            place_cursor(it.col, it.line);
         end else if (sel < 31) begin
            print_code(NEWLINE_CODE, it.color);
         end else if (sel < 33) begin
            drain_rows();
         end else begin
            // print a glyph, loading any rows still missing first
            code = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if (cur_height <= 8 && $urandom_range(0, 3) == 0) begin
               code = it.code;
               if (code == NEWLINE_CODE) code = NEWLINE_CODE + 8'd1;
            end
            for (int r = 0; r < cur_height; r++) begin
               if (!rows_loaded[code][r]) begin
                  it      = random_req();
                  it.mode = MODE_LOAD;
                  it.code = code;
                  it.row  = ROWIN_W'(r);
                  send_req(it);
               end
            end
            print_code(code, $urandom);
         end
      end
   endtask

   initial begin
      req_item_type      it;
      logic [MASK_W-1:0] directed_bits [8];
      directed_bits = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h00};
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_LOAD;
      req_ch.char_code   = '0;
      req_ch.glyph_row   = '0;
      req_ch.glyph_bits  = '0;
      req_ch.cursor_col  = '0;
      req_ch.cursor_line = '0;
      req_ch.color       = '0;
      rsp_ch.ready       = 1'b0;
      send_idle_pct      = 8;
      recv_idle_pct      = 83;
      cur_height         = int'(GLYPH_HEIGHT_RESET);
      foreach (rows_loaded[g]) rows_loaded[g] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: small geometry so wraps come quickly
      set_reg(REG_FRAME_WIDTH, 32'd24);
      set_reg(REG_PIXELS_PER_SL, 32'd16383);
      set_reg(REG_GLYPH_HEIGHT, 32'd4);
      it = random_req();
      send_req(it);
      for (int r = 0; r < 8; r++) begin
         it      = random_req();
         it.mode = MODE_LOAD;
         it.code = (r < 4) ? 8'h00 : 8'hFF;
         it.row  = ROWIN_W'(r % 4);
         it.bits = directed_bits[r];
         send_req(it);
      end
      // newline glyph can be loaded but never draws
      it      = random_req();
      it.mode = MODE_LOAD;
      it.code = NEWLINE_CODE;
      it.row  = 5'd31;
      it.bits = 8'hFF;
      send_req(it);
      place_cursor(16'd16, 16'd0);
      print_code(8'h00, 32'h0000_0000);
      print_code(8'hFF, 32'hFFFF_FFFF);
      print_code(NEWLINE_CODE, $urandom);
      // cursor at the top of both ranges
      place_cursor(16'hFFFF, 16'hFFFF);
      print_code(8'h00, 32'hA5A5_A5A5);
      print_code(8'hFF, $urandom);
      place_cursor(16'hFFF8, 16'hFFFE);
      print_code(8'h00, $urandom);
      print_code(NEWLINE_CODE, $urandom);

      // random phases across register extremes and idling patterns
      run_phase(32'd16383, 32'd8192, 32'd32, 8, 83);
      run_phase(32'd0, 32'd0, 32'd63, 8, 83);
      run_phase(32'd8, 32'd1, 32'd0, 83, 8);
      run_phase(32'd640, 32'd16383, 32'd8, 83, 8);
      run_phase(32'd100, 32'd640, 32'd1, 0, 0);
      run_phase(32'd1024, 32'd1024, 32'd16, 0, 0);

      drain_rows();
      if (fail_count == 0) begin
         $display("tb_glyph_text_renderer_unit: PASS");
      end else begin
         $display("tb_glyph_text_renderer_unit: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_glyph_text_renderer_unit: FAIL");
      $finish;
   end

endmodule
